// ===== rtl/first_fit_heap_allocator_unit_assert.svh =====
// assertion macros for the allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

`define FFHA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffha assertion failed");

`define FFHA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffha assertion failed");

`endif

// ===== rtl/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;
   localparam int HEAP_UNITS    = 1024;
   localparam int FREE_ENTRIES  = 16;
   localparam int ALLOC_ENTRIES = 16;

   localparam int MODE_W   = 2;
   localparam int HANDLE_W = 8;
   localparam int REQ_W    = 11;
   localparam int OVH_W    = 8;
   localparam int STATUS_W = 3;
   localparam int ADDR_W   = 10;
   localparam int GSIZE_W  = 11;

   localparam int UNIT_W = $clog2(HEAP_UNITS + 1);
   localparam int TOT_W  = REQ_W + 1;
   localparam int CMP_W  = (UNIT_W > TOT_W) ? UNIT_W : TOT_W;
   localparam int FI_W   = $clog2(FREE_ENTRIES);
   localparam int FC_W   = $clog2(FREE_ENTRIES + 1);
   localparam int AI_W   = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
   localparam int AC_W   = $clog2(ALLOC_ENTRIES + 1);
   localparam int SCAN_W = (FC_W > AC_W) ? FC_W : AC_W;
   localparam int KEY_W  = UNIT_W + FI_W;

   localparam int FREE_W  = 2 * UNIT_W;
   localparam int ALLOC_W = HANDLE_W + 2 * UNIT_W;

   localparam int REQ_DATA_W = ((HANDLE_W + REQ_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ADDR_W + GSIZE_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC, MODE_FREE, MODE_COALESCE, MODE_NOP
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK, ST_NO_FREE, ST_DUP, ST_NOT_ENOUGH,
      ST_NOT_FOUND, ST_ALLOC_FULL, ST_FREE_FULL, ST_NO_MERGE
   } status_type;

   typedef struct packed {
      logic              we;
      logic [FI_W-1:0]   waddr;
      logic [FI_W-1:0]   raddr;
      logic [FREE_W-1:0] wdata;
   } fram_ctl_type;

   typedef struct packed {
      logic               we;
      logic [AI_W-1:0]    waddr;
      logic [AI_W-1:0]    raddr;
      logic [ALLOC_W-1:0] wdata;
   } aram_ctl_type;
endpackage
`default_nettype wire

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// Allocate checks the allocation table for the handle, then takes the first free block that fits,
// dropping it from the free list if it empties; free moves a block to the front of the free list.
// One request at a time; each table scan reads one RAM entry per cycle on its single read port.
// A result waits in the output register while the next request is taken.
// Reset (synchronous, active high) is followed by an init state that writes the initial free block.
`default_nettype none
module first_fit_heap_allocator_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [ffha_pkg::MODE_W-1:0]       req_tuser,  // mode
   input  wire logic [ffha_pkg::REQ_DATA_W-1:0]   req_tdata,  // handle, request_size
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [ffha_pkg::STATUS_W-1:0]          rsp_tuser,  // status
   output logic [ffha_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // address, granted_size
   input  wire logic                              csr_we,
   input  wire logic [ffha_pkg::OVH_W-1:0]        csr_wdata
);
   import ffha_pkg::*;

   fram_ctl_type        free_ctl, scr_ctl;
   aram_ctl_type        alloc_ctl;
   logic [FREE_W-1:0]   free_rd, scr_rd;
   logic [ALLOC_W-1:0]  alloc_rd;

   ffha_ram #(.WIDTH(FREE_W), .DEPTH(FREE_ENTRIES)) u_free_ram (
      .clock (clock),
      .we    (free_ctl.we),
      .waddr (free_ctl.waddr),
      .wdata (free_ctl.wdata),
      .raddr (free_ctl.raddr),
      .rdata (free_rd)
   );

   ffha_ram #(.WIDTH(ALLOC_W), .DEPTH(ALLOC_ENTRIES)) u_alloc_ram (
      .clock (clock),
      .we    (alloc_ctl.we),
      .waddr (alloc_ctl.waddr),
      .wdata (alloc_ctl.wdata),
      .raddr (alloc_ctl.raddr),
      .rdata (alloc_rd)
   );

   ffha_ram #(.WIDTH(FREE_W), .DEPTH(FREE_ENTRIES)) u_scr_ram (
      .clock (clock),
      .we    (scr_ctl.we),
      .waddr (scr_ctl.waddr),
      .wdata (scr_ctl.wdata),
      .raddr (scr_ctl.raddr),
      .rdata (scr_rd)
   );

   ffha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .free_ctl   (free_ctl),
      .free_rd    (free_rd),
      .alloc_ctl  (alloc_ctl),
      .alloc_rd   (alloc_rd),
      .scr_ctl    (scr_ctl),
      .scr_rd     (scr_rd)
   );
endmodule
`default_nettype wire

// ===== rtl/ffha_ram.sv =====
`default_nettype none
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== rtl/ffha_ctrl.sv =====
`default_nettype none
`include "first_fit_heap_allocator_unit_assert.svh"
module ffha_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [ffha_pkg::MODE_W-1:0]       req_tuser,
   input  wire logic [ffha_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [ffha_pkg::STATUS_W-1:0]          rsp_tuser,
   output logic [ffha_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [ffha_pkg::OVH_W-1:0]        csr_wdata,
   output ffha_pkg::fram_ctl_type                 free_ctl,
   input  wire logic [ffha_pkg::FREE_W-1:0]       free_rd,
   output ffha_pkg::aram_ctl_type                 alloc_ctl,
   input  wire logic [ffha_pkg::ALLOC_W-1:0]      alloc_rd,
   output ffha_pkg::fram_ctl_type                 scr_ctl,
   input  wire logic [ffha_pkg::FREE_W-1:0]       scr_rd
);
   import ffha_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DUP, S_FIT, S_FRM, S_FIND, S_ASH, S_FSH,
      S_CSEL, S_CWR, S_CMRG, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [HANDLE_W-1:0]  handle_ff, handle_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic [SCAN_W-1:0]    ptr_ff, ptr_in;
   logic [SCAN_W-1:0]    pidx_ff, pidx_in;
   logic                 pend_ff, pend_in;
   logic [FC_W-1:0]      fcount_ff, fcount_in;
   logic [AC_W-1:0]      acount_ff, acount_in;
   logic [OVH_W-1:0]     ovh_ff, ovh_in;
   status_type           res_status_ff, res_status_in;
   logic [UNIT_W-1:0]    res_addr_ff, res_addr_in;
   logic [UNIT_W-1:0]    res_size_ff, res_size_in;
   logic [FC_W-1:0]      pass_ff, pass_in;
   logic [KEY_W-1:0]     best_key_ff, best_key_in;
   logic [UNIT_W-1:0]    best_size_ff, best_size_in;
   logic                 best_vld_ff, best_vld_in;
   logic [KEY_W-1:0]     last_key_ff, last_key_in;
   logic                 have_last_ff, have_last_in;
   logic [UNIT_W-1:0]    prev_s_ff, prev_s_in;
   logic [UNIT_W-1:0]    prev_z_ff, prev_z_in;
   logic                 adj_ff, adj_in;
   logic [UNIT_W-1:0]    cur_s_ff, cur_s_in;
   logic [UNIT_W-1:0]    cur_z_ff, cur_z_in;
   logic [FC_W-1:0]      w_ff, w_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [GSIZE_W-1:0]   rsp_size_ff, rsp_size_in;

   logic [UNIT_W-1:0]    fr_start, fr_size, ar_start, ar_size, sr_start, sr_size;
   logic [HANDLE_W-1:0]  ar_handle;
   logic [SCAN_W-1:0]    pidx_m1, pidx_p1, ptr_m1;
   logic [KEY_W-1:0]     cand_key;
   logic [CMP_W-1:0]     new_size;
   logic [UNIT_W:0]      cur_end;
   mode_type             req_mode;

   assign fr_start  = free_rd[UNIT_W-1:0];
   assign fr_size   = free_rd[FREE_W-1:UNIT_W];
   assign sr_start  = scr_rd[UNIT_W-1:0];
   assign sr_size   = scr_rd[FREE_W-1:UNIT_W];
   assign ar_handle = alloc_rd[HANDLE_W-1:0];
   assign ar_start  = alloc_rd[HANDLE_W+UNIT_W-1:HANDLE_W];
   assign ar_size   = alloc_rd[ALLOC_W-1:HANDLE_W+UNIT_W];
   assign pidx_m1   = pidx_ff - 1'b1;
   assign pidx_p1   = pidx_ff + 1'b1;
   assign ptr_m1    = ptr_ff - 1'b1;
   assign cand_key  = {fr_start, pidx_ff[FI_W-1:0]};
   assign new_size  = CMP_W'(fr_size) - CMP_W'(total_ff);
   assign cur_end   = {1'b0, cur_s_ff} + {1'b0, cur_z_ff};
   assign req_mode  = mode_type'(req_tuser);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_size_ff, rsp_addr_ff});

   always_comb begin
      state_in      = state_ff;
      handle_in     = handle_ff;
      total_in      = total_ff;
      ptr_in        = ptr_ff;
      pidx_in       = pidx_ff;
      pend_in       = 1'b0;
      fcount_in     = fcount_ff;
      acount_in     = acount_ff;
      ovh_in        = ovh_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_size_in   = res_size_ff;
      pass_in       = pass_ff;
      best_key_in   = best_key_ff;
      best_size_in  = best_size_ff;
      best_vld_in   = best_vld_ff;
      last_key_in   = last_key_ff;
      have_last_in  = have_last_ff;
      prev_s_in     = prev_s_ff;
      prev_z_in     = prev_z_ff;
      adj_in        = adj_ff;
      cur_s_in      = cur_s_ff;
      cur_z_in      = cur_z_ff;
      w_in          = w_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;

      free_ctl       = '0;
      free_ctl.raddr = ptr_ff[FI_W-1:0];
      alloc_ctl       = '0;
      alloc_ctl.raddr = ptr_ff[AI_W-1:0];
      scr_ctl       = '0;
      scr_ctl.raddr = ptr_ff[FI_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_we) begin
         ovh_in = csr_wdata;
      end

      unique case (state_ff)
         S_INIT: begin
            free_ctl.we    = 1'b1;
            free_ctl.waddr = '0;
            free_ctl.wdata = {UNIT_W'(HEAP_UNITS), UNIT_W'(0)};
            state_in       = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               handle_in   = req_tdata[HANDLE_W-1:0];
               total_in    = TOT_W'(req_tdata[HANDLE_W+REQ_W-1:HANDLE_W]) + TOT_W'(ovh_ff);
               ptr_in      = '0;
               res_addr_in = '0;
               res_size_in = '0;
               unique case (req_mode)
                  MODE_ALLOC: begin
                     if (fcount_ff == '0) begin
                        res_status_in = ST_NO_FREE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_DUP;
                     end
                  end
                  MODE_FREE: begin
                     state_in = S_FIND;
                  end
                  MODE_COALESCE: begin
                     pass_in      = '0;
                     have_last_in = 1'b0;
                     best_vld_in  = 1'b0;
                     adj_in       = 1'b0;
                     if (fcount_ff < FC_W'(2)) begin
                        res_status_in = ST_NO_MERGE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_CSEL;
                     end
                  end
                  default: begin
                     res_status_in = ST_NO_MERGE;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_DUP: begin
            if (pend_ff && ar_handle == handle_ff) begin
               res_status_in = ST_DUP;
               state_in      = S_DONE;
            end else if (ptr_ff < SCAN_W'(acount_ff)) begin
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               ptr_in  = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               if (acount_ff >= AC_W'(ALLOC_ENTRIES)) begin
                  res_status_in = ST_ALLOC_FULL;
                  state_in      = S_DONE;
               end else begin
                  ptr_in   = '0;
                  state_in = S_FIT;
               end
            end
         end
         S_FIT: begin
            if (pend_ff && CMP_W'(fr_size) >= CMP_W'(total_ff)) begin
               res_addr_in     = fr_start;
               res_size_in     = UNIT_W'(total_ff);
               res_status_in   = ST_OK;
               alloc_ctl.we    = 1'b1;
               alloc_ctl.waddr = acount_ff[AI_W-1:0];
               alloc_ctl.wdata = {UNIT_W'(total_ff), fr_start, handle_ff};
               acount_in       = acount_ff + 1'b1;
               if (new_size != '0) begin
                  free_ctl.we    = 1'b1;
                  free_ctl.waddr = pidx_ff[FI_W-1:0];
                  free_ctl.wdata = {UNIT_W'(new_size),
                                    UNIT_W'(CMP_W'(fr_start) + CMP_W'(total_ff))};
                  state_in       = S_DONE;
               end else begin
                  ptr_in   = pidx_p1;
                  state_in = S_FRM;
               end
            end else if (ptr_ff < SCAN_W'(fcount_ff)) begin
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               ptr_in  = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               res_status_in = ST_NOT_ENOUGH;
               state_in      = S_DONE;
            end
         end
         S_FRM: begin
            if (pend_ff) begin
               free_ctl.we    = 1'b1;
               free_ctl.waddr = pidx_m1[FI_W-1:0];
               free_ctl.wdata = free_rd;
            end
            if (ptr_ff < SCAN_W'(fcount_ff)) begin
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               ptr_in  = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               fcount_in = fcount_ff - 1'b1;
               state_in  = S_DONE;
            end
         end
         S_FIND: begin
            if (pend_ff && ar_handle == handle_ff) begin
               if (fcount_ff >= FC_W'(FREE_ENTRIES)) begin
                  res_status_in = ST_FREE_FULL;
                  state_in      = S_DONE;
               end else begin
                  res_addr_in   = ar_start;
                  res_size_in   = ar_size;
                  res_status_in = ST_OK;
                  ptr_in        = pidx_p1;
                  state_in      = S_ASH;
               end
            end else if (ptr_ff < SCAN_W'(acount_ff)) begin
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               ptr_in  = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_DONE;
            end
         end
         S_ASH: begin
            if (pend_ff) begin
               alloc_ctl.we    = 1'b1;
               alloc_ctl.waddr = pidx_m1[AI_W-1:0];
               alloc_ctl.wdata = alloc_rd;
            end
            if (ptr_ff < SCAN_W'(acount_ff)) begin
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               ptr_in  = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               acount_in = acount_ff - 1'b1;
               ptr_in    = SCAN_W'(fcount_ff);
               state_in  = S_FSH;
            end
         end
         S_FSH: begin
            // shift the free list up by one, top entry first
            free_ctl.raddr = ptr_m1[FI_W-1:0];
            if (pend_ff) begin
               free_ctl.we    = 1'b1;
               free_ctl.waddr = pidx_p1[FI_W-1:0];
               free_ctl.wdata = free_rd;
            end
            if (ptr_ff != '0) begin
               pend_in = 1'b1;
               pidx_in = ptr_m1;
               ptr_in  = ptr_m1;
            end else if (!pend_ff) begin
               free_ctl.we    = 1'b1;
               free_ctl.waddr = '0;
               free_ctl.wdata = {res_size_ff, res_addr_ff};
               fcount_in      = fcount_ff + 1'b1;
               state_in       = S_DONE;
            end
         end
         S_CSEL: begin
            // stable selection: smallest (start, index) above the last pick
            if (pend_ff && (!have_last_ff || cand_key > last_key_ff) &&
                (!best_vld_ff || cand_key < best_key_ff)) begin
               best_key_in  = cand_key;
               best_size_in = fr_size;
               best_vld_in  = 1'b1;
            end
            if (ptr_ff < SCAN_W'(fcount_ff)) begin
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               ptr_in  = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = S_CWR;
            end
         end
         S_CWR: begin
            scr_ctl.we    = 1'b1;
            scr_ctl.waddr = pass_ff[FI_W-1:0];
            scr_ctl.wdata = {best_size_ff, best_key_ff[KEY_W-1:FI_W]};
            if (pass_ff != '0 &&
                ({1'b0, prev_s_ff} + {1'b0, prev_z_ff}) ==
                {1'b0, best_key_ff[KEY_W-1:FI_W]}) begin
               adj_in = 1'b1;
            end
            prev_s_in    = best_key_ff[KEY_W-1:FI_W];
            prev_z_in    = best_size_ff;
            last_key_in  = best_key_ff;
            have_last_in = 1'b1;
            best_vld_in  = 1'b0;
            pass_in      = pass_ff + 1'b1;
            ptr_in       = '0;
            if (pass_ff + 1'b1 == fcount_ff) begin
               if (adj_in) begin
                  w_in     = '0;
                  state_in = S_CMRG;
               end else begin
                  res_status_in = ST_NO_MERGE;
                  state_in      = S_DONE;
               end
            end else begin
               state_in = S_CSEL;
            end
         end
         S_CMRG: begin
            if (pend_ff) begin
               if (pidx_ff == '0) begin
                  cur_s_in = sr_start;
                  cur_z_in = sr_size;
               end else if (cur_end == {1'b0, sr_start}) begin
                  cur_z_in = cur_z_ff + sr_size;
               end else begin
                  free_ctl.we    = 1'b1;
                  free_ctl.waddr = w_ff[FI_W-1:0];
                  free_ctl.wdata = {cur_z_ff, cur_s_ff};
                  w_in           = w_ff + 1'b1;
                  cur_s_in       = sr_start;
                  cur_z_in       = sr_size;
               end
            end
            if (ptr_ff < SCAN_W'(fcount_ff)) begin
               pend_in = 1'b1;
               pidx_in = ptr_ff;
               ptr_in  = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               free_ctl.we    = 1'b1;
               free_ctl.waddr = w_ff[FI_W-1:0];
               free_ctl.wdata = {cur_z_ff, cur_s_ff};
               fcount_in      = w_ff + 1'b1;
               res_status_in  = ST_OK;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = ADDR_W'(res_addr_ff);
               rsp_size_in   = GSIZE_W'(res_size_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pend_ff      <= 1'b0;
         fcount_ff    <= FC_W'(1);
         acount_ff    <= '0;
         ovh_ff       <= OVH_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         fcount_ff    <= fcount_in;
         acount_ff    <= acount_in;
         ovh_ff       <= ovh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      handle_ff     <= handle_in;
      total_ff      <= total_in;
      ptr_ff        <= ptr_in;
      pidx_ff       <= pidx_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_size_ff   <= res_size_in;
      pass_ff       <= pass_in;
      best_key_ff   <= best_key_in;
      best_size_ff  <= best_size_in;
      best_vld_ff   <= best_vld_in;
      last_key_ff   <= last_key_in;
      have_last_ff  <= have_last_in;
      prev_s_ff     <= prev_s_in;
      prev_z_ff     <= prev_z_in;
      adj_ff        <= adj_in;
      cur_s_ff      <= cur_s_in;
      cur_z_ff      <= cur_z_in;
      w_ff          <= w_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
   end

   `FFHA_ASSERT_IMP(a_fcount_max, clock, reset, 1'b1, fcount_ff <= FC_W'(FREE_ENTRIES))
   `FFHA_ASSERT_IMP(a_acount_max, clock, reset, 1'b1, acount_ff <= AC_W'(ALLOC_ENTRIES))
   `FFHA_ASSERT_NXT(a_req_busy, clock, reset, req_tvalid && req_tready, state_ff != S_IDLE)
   `FFHA_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_DONE)
endmodule
`default_nettype wire

// ===== bench/first_fit_heap_allocator_unit_test.sv =====
`default_nettype none
module first_fit_heap_allocator_unit_test;
   import ffha_pkg::*;

   typedef struct {
      mode_type    mode;
      logic [7:0]  handle;
      logic [10:0] size;
   } heap_request_type;

   typedef struct {
      status_type  status;
      logic [9:0]  address;
      logic [10:0] granted;
   } heap_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [MODE_W-1:0] req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [STATUS_W-1:0] rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [OVH_W-1:0] csr_wdata = '0;

   first_fit_heap_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   heap_request_type pending_requests[$];
   heap_response_type expected_responses[$];
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatches = 0;
   int responses_seen = 0;
   int merges_seen = 0;

   // allocator shadow state
   int overhead = 2;
   int free_start[FREE_ENTRIES];
   int free_size[FREE_ENTRIES];
   int free_count;
   int held_handle[ALLOC_ENTRIES];
   int held_start[ALLOC_ENTRIES];
   int held_size[ALLOC_ENTRIES];
   int held_count;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic predict_response(input heap_request_type rq, output heap_response_type rs);
      int i, k, w, total, addr, sz, cs, cz, j, n;
      int s[FREE_ENTRIES];
      int z[FREE_ENTRIES];
      bit hit;
      rs.status = ST_OK;
      addr = 0;
      sz = 0;
      case (rq.mode)
         MODE_ALLOC: begin
            total = int'(rq.size) + overhead;
            hit = 0;
            for (i = 0; i < held_count; i++) if (held_handle[i] == rq.handle) hit = 1;
            if (free_count == 0) rs.status = ST_NO_FREE;
            else if (hit) rs.status = ST_DUP;
            else if (held_count >= ALLOC_ENTRIES) rs.status = ST_ALLOC_FULL;
            else begin
               for (i = 0; i < free_count; i++) if (free_size[i] >= total) break;
               if (i >= free_count) rs.status = ST_NOT_ENOUGH;
               else begin
                  addr = free_start[i];
                  sz = total;
                  free_start[i] += total;
                  free_size[i] -= total;
                  if (free_size[i] == 0) begin
                     for (k = i; k + 1 < free_count; k++) begin
                        free_start[k] = free_start[k+1];
                        free_size[k] = free_size[k+1];
                     end
                     free_count--;
                  end
                  held_handle[held_count] = rq.handle;
                  held_start[held_count] = addr;
                  held_size[held_count] = total;
                  held_count++;
               end
            end
         end
         MODE_FREE: begin
            for (i = 0; i < held_count; i++) if (held_handle[i] == rq.handle) break;
            if (i >= held_count) rs.status = ST_NOT_FOUND;
            else if (free_count >= FREE_ENTRIES) rs.status = ST_FREE_FULL;
            else begin
               addr = held_start[i];
               sz = held_size[i];
               for (k = i; k + 1 < held_count; k++) begin
                  held_handle[k] = held_handle[k+1];
                  held_start[k] = held_start[k+1];
                  held_size[k] = held_size[k+1];
               end
               held_count--;
               for (k = free_count; k > 0; k--) begin
                  free_start[k] = free_start[k-1];
                  free_size[k] = free_size[k-1];
               end
               free_start[0] = addr;
               free_size[0] = sz;
               free_count++;
            end
         end
         MODE_COALESCE: begin
            n = free_count;
            for (i = 0; i < n; i++) begin
               cs = free_start[i];
               cz = free_size[i];
               j = i;
               while (j > 0 && s[j-1] > cs) begin
                  s[j] = s[j-1];
                  z[j] = z[j-1];
                  j--;
               end
               s[j] = cs;
               z[j] = cz;
            end
            hit = 0;
            for (i = 0; i + 1 < n; i++) if (s[i] + z[i] == s[i+1]) hit = 1;
            if (!hit) rs.status = ST_NO_MERGE;
            else begin
               w = 0;
               for (i = 1; i < n; i++) begin
                  if (s[w] + z[w] == s[i]) z[w] += z[i];
                  else begin
                     w++;
                     s[w] = s[i];
                     z[w] = z[i];
                  end
               end
               free_count = w + 1;
               for (i = 0; i < FREE_ENTRIES; i++) begin
                  free_start[i] = (i <= w) ? s[i] : 0;
                  free_size[i] = (i <= w) ? z[i] : 0;
               end
            end
         end
         default: rs.status = ST_NO_MERGE;
      endcase
      rs.address = addr[9:0];
      rs.granted = sz[10:0];
   endtask

   // driver
   always @(posedge clock) begin
      heap_response_type rs;
      heap_request_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rq.mode = mode_type'(req_tuser);
            rq.handle = req_tdata[7:0];
            rq.size = req_tdata[18:8];
            predict_response(rq, rs);
            expected_responses.insert(expected_responses.size(), rs);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               rq = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= rq.mode;
               req_tdata <= {5'b0, rq.size, rq.handle};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      heap_response_type ex;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            if (expected_responses.size() == 0) begin
               $error("unexpected response status=%0d", rsp_tuser);
               mismatches++;
            end else begin
               ex = expected_responses.pop_front();
               if (ex.status == ST_OK && ex.granted == 0 && ex.address == 0) merges_seen++;
               if (rsp_tuser !== ex.status) begin
                  $error("status expected %0d actual %0d", ex.status, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[9:0] !== ex.address) begin
                  $error("address expected %0d actual %0d", ex.address, rsp_tdata[9:0]);
                  mismatches++;
               end
               if (rsp_tdata[20:10] !== ex.granted) begin
                  $error("granted_size expected %0d actual %0d", ex.granted,
                         rsp_tdata[20:10]);
                  mismatches++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic queue_request(input mode_type m, input int h, input int sz);
      heap_request_type rq;
      rq.mode = m;
      rq.handle = h[7:0];
      rq.size = sz[10:0];
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   task automatic write_overhead(input int v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v[7:0];
      overhead = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      while (pending_requests.size() > 0 || req_tvalid || expected_responses.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      int r, sz;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         sz = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 90);
         if (r < 46) queue_request(MODE_ALLOC, $urandom_range(23), sz);
         else if (r < 84) queue_request(MODE_FREE, $urandom_range(23), 0);
         else if (r < 94) queue_request(MODE_COALESCE, $urandom_range(255), $urandom_range(2047));
         else if (r < 97) queue_request(MODE_NOP, $urandom_range(255), $urandom_range(2047));
         else queue_request(mode_type'($urandom_range(1)), $urandom_range(255),
                            $urandom_range(2047));
      end
   endtask

   initial begin
      int settings[5];
      settings = '{0, 255, 2, 7, 1};
      for (int i = 0; i < FREE_ENTRIES; i++) begin
         free_start[i] = 0;
         free_size[i] = 0;
      end
      free_size[0] = HEAP_UNITS;
      free_count = 1;
      held_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      write_overhead(0);
      queue_request(MODE_FREE, 5, 0);
      queue_request(MODE_COALESCE, 0, 0);
      queue_request(MODE_NOP, 255, 2047);
      queue_request(MODE_ALLOC, 255, 0);
      queue_request(MODE_ALLOC, 255, 4);
      queue_request(MODE_ALLOC, 1, 1024);
      queue_request(MODE_ALLOC, 2, 1);
      queue_request(MODE_FREE, 1, 0);
      queue_request(MODE_FREE, 255, 0);
      queue_request(MODE_COALESCE, 0, 0);
      queue_request(MODE_ALLOC, 3, 2047);
      queue_request(MODE_ALLOC, 4, 1023);
      queue_request(MODE_FREE, 4, 0);
      queue_request(MODE_COALESCE, 0, 0);
      drain();

      for (int p = 0; p < 5; p++) begin
         write_overhead(p == 3 ? $urandom_range(255) : settings[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
            default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
         endcase
         queue_random(228);
         drain();
      end

      repeat (400) @(posedge clock);
      $display("Checked %0d allocator responses in six phases with varied overhead,",
               responses_seen);
      $display("with mixed allocate/free/coalesce traffic and %0d zero-payload ok responses.",
               merges_seen);
      if (mismatches == 0 && expected_responses.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #30000000;
      $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator_unit.sv
bench/first_fit_heap_allocator_unit_test.sv
